@@ rtl/bb3_pkg.sv @@
// bb3_pkg: shared types, constants and helpers for the 3x3 RGB box blur.
// No dependencies; every other file but bb3_ram refers to it by scoped names.

package bb3_pkg;

  // Pixel layout
  localparam int BYTE_W    = 8;
  localparam int CH_N      = 3;
  localparam int RGB_W     = CH_N * BYTE_W;
  localparam int DATA_W    = 32;
  localparam int COL_SUM_W = 10;  // three bytes
  localparam int WIN_SUM_W = 12;  // nine bytes

  // Configuration registers
  localparam int FW_W        = 11;
  localparam int FH_W        = 13;
  localparam int ADDR_W      = 3;
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;
  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  // Input beat kinds
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_PAD   = 1'b1;

  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // Divide by nine: multiply by ceil(2^16 / 9), exact for sums up to 9 * 255
  localparam int RECIP_W    = 13;
  localparam int PROD_W     = WIN_SUM_W + RECIP_W;
  localparam int DIV9_SHIFT = 16;
  localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;

  typedef logic [RGB_W-1:0] rgb_t;

  // Current column of the window, as the front end hands it over
  typedef struct packed {
    logic col0;
    logic emit;
    logic last;
    rgb_t top;
    rgb_t mid;
    rgb_t bot;
  } bb3_cur_t;

  // Window sums of one result
  typedef struct packed {
    logic                                last;
    logic [CH_N-1:0][WIN_SUM_W-1:0]      sum;
  } bb3_sum_t;

  // Channel 0 is red, 1 green, 2 blue
  function automatic logic [BYTE_W-1:0] chan(input rgb_t px, input int ch);
    return px[RGB_W-1-BYTE_W*ch -: BYTE_W];
  endfunction

  function automatic logic [BYTE_W-1:0] div9(input logic [WIN_SUM_W-1:0] s);
    logic [PROD_W-1:0] p;
    p = {{RECIP_W{1'b0}}, s} * {{WIN_SUM_W{1'b0}}, DIV9_RECIP};
    return p[DIV9_SHIFT +: BYTE_W];
  endfunction

endpackage

@@ rtl/bb3_ram.sv @@
// bb3_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and read ports; read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/bb3_seq.sv @@
// bb3_seq: front end of the blur - raster counters, line store access with
// write bypass, and the input register. Depends on bb3_pkg.

module bb3_seq #(
  parameter int MAX_LINE = 1024,
  parameter int MAX_ROWS = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        restart,
  input  logic [bb3_pkg::FW_W-1:0]    frame_width,
  input  logic [bb3_pkg::FH_W-1:0]    frame_height,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [bb3_pkg::DATA_W-1:0]  in_source_pixel,
  input  logic                        s2_rdy,
  output logic                        rd_en,
  output logic [$clog2(MAX_LINE)-1:0] rd_addr,
  input  bb3_pkg::rgb_t               older_q,
  input  bb3_pkg::rgb_t               newer_q,
  output logic                        wr_en,
  output logic [$clog2(MAX_LINE)-1:0] wr_addr,
  output bb3_pkg::rgb_t               wr_older,
  output bb3_pkg::rgb_t               wr_newer,
  output logic                        s1_valid,
  output bb3_pkg::bb3_cur_t           s1_cur
);

  localparam int COL_W  = $clog2(MAX_LINE);
  localparam int W_W    = $clog2(MAX_LINE + 1);
  localparam int H_W    = $clog2(MAX_ROWS + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS + 2);
  localparam int OROW_W = $clog2(MAX_ROWS + 1);

  logic [W_W-1:0]    eff_w;
  logic [H_W-1:0]    eff_h;
  logic [COL_W-1:0]  col_r, col_nxt, ocol_r, ocol_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [OROW_W-1:0] orow_r, orow_nxt;
  logic              row_lt_h, row_le_h, row_ge1, row_ge2, col0;
  logic              ignore, take, emit, last, col_wrap, ocol_wrap, orow_end;
  logic              s1_fire, fwd_hit;
  bb3_pkg::rgb_t     pix, older_raw, newer_raw;

  logic              s1_valid_r, s1_valid_nxt;
  logic [COL_W-1:0]  s1_col_r;
  bb3_pkg::rgb_t     s1_pix_r, s1_fwd_older_r, s1_fwd_newer_r;
  logic              s1_col0_r, s1_use_older_r, s1_use_newer_r, s1_emit_r, s1_last_r;
  logic              s1_fwd_r;

  // Clamp the frame size registers to the supported range
  always_comb begin
    if (frame_width == '0) begin
      eff_w = W_W'(1);
    end else if (32'(frame_width) > 32'(MAX_LINE)) begin
      eff_w = W_W'(MAX_LINE);
    end else begin
      eff_w = W_W'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = H_W'(1);
    end else if (32'(frame_height) > 32'(MAX_ROWS)) begin
      eff_h = H_W'(MAX_ROWS);
    end else begin
      eff_h = H_W'(frame_height);
    end
  end

  // Decode the raster position
  assign row_lt_h  = 32'(row_r) < 32'(eff_h);
  assign row_le_h  = 32'(row_r) <= 32'(eff_h);
  assign row_ge1   = row_r != '0;
  assign row_ge2   = 32'(row_r) >= 32'd2;
  assign col0      = col_r == '0;
  assign col_wrap  = 32'(col_r) + 32'd1 >= 32'(eff_w);
  assign ocol_wrap = 32'(ocol_r) + 32'd1 >= 32'(eff_w);
  assign orow_end  = 32'(orow_r) + 32'd1 >= 32'(eff_h);
  assign emit      = col0 ? row_ge2 : row_ge1;
  assign last      = emit && ocol_wrap && orow_end;

  // Handshake: pads inside the frame are taken and dropped
  assign s1_fire  = s1_valid_r && s2_rdy;
  assign in_ready = !s1_valid_r || s2_rdy;
  assign ignore   = (in_action == bb3_pkg::ACT_PAD) && row_lt_h;
  assign take     = in_valid && in_ready && !ignore;
  assign pix      = row_lt_h ? in_source_pixel[bb3_pkg::DATA_W-1 -: bb3_pkg::RGB_W] : '0;

  // Advance counters; frame end and register writes restart the frame
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (restart || (take && last)) begin
      col_nxt  = '0;
      row_nxt  = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
    end else if (take) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
      if (emit) begin
        if (ocol_wrap) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + OROW_W'(1);
        end else begin
          ocol_nxt = ocol_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      ocol_r <= '0;
      orow_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
    end
  end

  // Line store data, bypassing a write that lands on the edge of the read
  assign older_raw = s1_fwd_r ? s1_fwd_older_r : older_q;
  assign newer_raw = s1_fwd_r ? s1_fwd_newer_r : newer_q;
  assign fwd_hit   = s1_fire && (s1_col_r == col_r);

  // Read at acceptance, shift the column down one row when the beat leaves
  assign rd_en    = take;
  assign rd_addr  = col_r;
  assign wr_en    = s1_fire;
  assign wr_addr  = s1_col_r;
  assign wr_older = newer_raw;
  assign wr_newer = s1_pix_r;

  // Input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_col_r       <= col_r;
      s1_pix_r       <= pix;
      s1_col0_r      <= col0;
      s1_use_older_r <= row_ge2;
      s1_use_newer_r <= row_ge1 && row_le_h;
      s1_emit_r      <= emit;
      s1_last_r      <= last;
      s1_fwd_r       <= fwd_hit;
      s1_fwd_older_r <= newer_raw;
      s1_fwd_newer_r <= s1_pix_r;
    end
  end

  // Mask rows above the top edge and hand the column over
  always_comb begin
    s1_cur.col0 = s1_col0_r;
    s1_cur.emit = s1_emit_r;
    s1_cur.last = s1_last_r;
    s1_cur.top  = s1_use_older_r ? older_raw : '0;
    s1_cur.mid  = s1_use_newer_r ? newer_raw : '0;
    s1_cur.bot  = s1_pix_r;
  end

  assign s1_valid = s1_valid_r;

endmodule

@@ rtl/bb3_win.sv @@
// bb3_win: 3x3 window held as per-column channel sums, and the sum register.
// Depends on bb3_pkg.

module bb3_win (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              s1_valid,
  input  bb3_pkg::bb3_cur_t s1_cur,
  output logic              s2_rdy,
  input  logic              s3_rdy,
  output logic              s2_valid,
  output bb3_pkg::bb3_sum_t s2_sum
);

  localparam int CH_N = bb3_pkg::CH_N;
  localparam int CS_W = bb3_pkg::COL_SUM_W;
  localparam int WS_W = bb3_pkg::WIN_SUM_W;

  logic [CH_N-1:0][CS_W-1:0] win_a_r, win_a_nxt, win_b_r, win_b_nxt, cur_sum;
  logic [CH_N-1:0][WS_W-1:0] tot;
  logic                      s1_fire;
  logic                      s2_valid_r, s2_valid_nxt;
  bb3_pkg::bb3_sum_t         s2_r;

  assign s2_rdy  = !s2_valid_r || s3_rdy;
  assign s1_fire = s1_valid && s2_rdy;

  // Column sum of the new column and the window total
  always_comb begin
    for (int ch = 0; ch < CH_N; ch++) begin
      cur_sum[ch] = CS_W'(bb3_pkg::chan(s1_cur.top, ch))
                  + CS_W'(bb3_pkg::chan(s1_cur.mid, ch))
                  + CS_W'(bb3_pkg::chan(s1_cur.bot, ch));
      tot[ch] = WS_W'(win_a_r[ch]) + WS_W'(win_b_r[ch])
              + (s1_cur.col0 ? {WS_W{1'b0}} : WS_W'(cur_sum[ch]));
    end
  end

  // Shift the window; a new row starts with an empty left column
  always_comb begin
    win_a_nxt = win_a_r;
    win_b_nxt = win_b_r;
    if (clear || (s1_fire && s1_cur.last)) begin
      win_a_nxt = '0;
      win_b_nxt = '0;
    end else if (s1_fire) begin
      win_a_nxt = s1_cur.col0 ? '0 : win_b_r;
      win_b_nxt = cur_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_a_r <= '0;
      win_b_r <= '0;
    end else begin
      win_a_r <= win_a_nxt;
      win_b_r <= win_b_nxt;
    end
  end

  // Sum register: only beats that produce a result move on
  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (s1_fire) begin
      s2_valid_nxt = s1_cur.emit;
    end else if (s3_rdy) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_cur.emit) begin
      s2_r.last <= s1_cur.last;
      s2_r.sum  <= tot;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_sum   = s2_r;

endmodule

@@ rtl/bb3_div.sv @@
// bb3_div: divide the window sums by nine, pack RGBA and hold the result beat.
// Depends on bb3_pkg.

module bb3_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       s2_valid,
  input  bb3_pkg::bb3_sum_t          s2_sum,
  output logic                       s3_rdy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bb3_pkg::DATA_W-1:0] out_blurred_pixel,
  output logic                       out_last_of_frame
);

  logic                       s2_fire;
  logic                       out_valid_r, out_valid_nxt;
  logic [bb3_pkg::DATA_W-1:0] pixel_nxt, pixel_r;
  logic                       last_r;

  assign s3_rdy  = !out_valid_r || out_ready;
  assign s2_fire = s2_valid && s3_rdy;

  // Average each channel and set alpha opaque
  assign pixel_nxt = {bb3_pkg::div9(s2_sum.sum[0]),
                      bb3_pkg::div9(s2_sum.sum[1]),
                      bb3_pkg::div9(s2_sum.sum[2]),
                      bb3_pkg::ALPHA_OPAQUE};

  // Output register: hold while stalled
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      pixel_r <= pixel_nxt;
      last_r  <= s2_sum.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_blurred_pixel = pixel_r;
  assign out_last_of_frame = last_r;

endmodule

@@ rtl/box_blur_3x3_rgb.sv @@
// box_blur_3x3_rgb: top level of the streaming 3x3 RGB box blur.
// Depends on bb3_pkg, bb3_ram, bb3_seq, bb3_win and bb3_div.
//
// Channel  Dir  Handshake              Beat contents
// in_      in   in_valid / in_ready    in_action, in_source_pixel
// out_     out  out_valid / out_ready  out_blurred_pixel, out_last_of_frame
// cfg_     in   APB, pready tied high  frame_width at 0x0, frame_height at 0x4
//
// One beat per clock sustained while out_ready stays high. The beat that
// completes a window passes the input register (line store read), the sum
// register and the output register. The line stores are read as a beat is
// taken and written as the beat leaves the input register, with a bypass for
// back-to-back beats on one column.
// Reset is synchronous on rst_n; the line stores are not cleared (rows above
// the top edge are masked), so no clearing pass follows reset.
// out_ready low backs up through the three registers; in_ready drops only
// once all of them are full.

module box_blur_3x3_rgb #(
  parameter int MAX_LINE = 1024,
  parameter int MAX_ROWS = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [bb3_pkg::DATA_W-1:0] in_source_pixel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bb3_pkg::DATA_W-1:0] out_blurred_pixel,
  output logic                       out_last_of_frame,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [bb3_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [bb3_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [bb3_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int LINE_AW = $clog2(MAX_LINE);

  logic [bb3_pkg::FW_W-1:0] frame_width_r;
  logic [bb3_pkg::FH_W-1:0] frame_height_r;
  logic                     cfg_wr;

  logic                     rd_en, wr_en;
  logic [LINE_AW-1:0]       rd_addr, wr_addr;
  bb3_pkg::rgb_t            older_q, newer_q, wr_older, wr_newer;
  logic                     s1_valid, s2_rdy, s2_valid, s3_rdy;
  bb3_pkg::bb3_cur_t        s1_cur;
  bb3_pkg::bb3_sum_t        s2_sum;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bb3_pkg::FW_RESET;
      frame_height_r <= bb3_pkg::FH_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[bb3_pkg::REG_SEL_BIT])
        bb3_pkg::REG_FRAME_WIDTH: begin
          frame_width_r <= cfg_pwdata[bb3_pkg::FW_W-1:0];
        end
        bb3_pkg::REG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_pwdata[bb3_pkg::FH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[bb3_pkg::REG_SEL_BIT])
      bb3_pkg::REG_FRAME_WIDTH:  cfg_prdata = bb3_pkg::DATA_W'(frame_width_r);
      bb3_pkg::REG_FRAME_HEIGHT: cfg_prdata = bb3_pkg::DATA_W'(frame_height_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // Line stores: two rows above the current one
  bb3_ram #(
    .WIDTH(bb3_pkg::RGB_W),
    .DEPTH(MAX_LINE)
  ) u_older_line (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_older),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(older_q)
  );

  bb3_ram #(
    .WIDTH(bb3_pkg::RGB_W),
    .DEPTH(MAX_LINE)
  ) u_newer_line (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_newer),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(newer_q)
  );

  bb3_seq #(
    .MAX_LINE(MAX_LINE),
    .MAX_ROWS(MAX_ROWS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .restart        (cfg_wr),
    .frame_width    (frame_width_r),
    .frame_height   (frame_height_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_source_pixel(in_source_pixel),
    .s2_rdy         (s2_rdy),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .older_q        (older_q),
    .newer_q        (newer_q),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_older       (wr_older),
    .wr_newer       (wr_newer),
    .s1_valid       (s1_valid),
    .s1_cur         (s1_cur)
  );

  bb3_win u_win (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (cfg_wr),
    .s1_valid(s1_valid),
    .s1_cur  (s1_cur),
    .s2_rdy  (s2_rdy),
    .s3_rdy  (s3_rdy),
    .s2_valid(s2_valid),
    .s2_sum  (s2_sum)
  );

  bb3_div u_div (
    .clk              (clk),
    .rst_n            (rst_n),
    .s2_valid         (s2_valid),
    .s2_sum           (s2_sum),
    .s3_rdy           (s3_rdy),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_blurred_pixel(out_blurred_pixel),
    .out_last_of_frame(out_last_of_frame)
  );

endmodule

@@ rtl/bb3_chk.sv @@
// bb3_chk: port-level checks of box_blur_3x3_rgb, bound to the top level.
// Depends on bb3_pkg and box_blur_3x3_rgb.

module bb3_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [bb3_pkg::DATA_W-1:0] out_blurred_pixel,
  input logic                       out_last_of_frame
);

  // Every result beat is opaque
  a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_blurred_pixel[bb3_pkg::BYTE_W-1:0] == bb3_pkg::ALPHA_OPAQUE)
    else $error("result beat with alpha byte other than opaque");

  // An empty output register leaves room all the way back to the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

  // Reset leaves no result beat behind
  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat present right after reset");

  // A stalled result beat holds
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_blurred_pixel)
      && $stable(out_last_of_frame))
    else $error("result beat changed or dropped while stalled");

endmodule

bind box_blur_3x3_rgb bb3_chk u_bb3_chk (.*);

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking bench for the streaming 3x3 RGB box blur.
// Depends on bb3_pkg and box_blur_3x3_rgb; a directed script runs first, then random frames
// whose blurred pixels are predicted by a behavioral copy of the blur kept in this file.

module tb_top;

  localparam int MAX_LINE      = 1024;
  localparam int MAX_ROWS      = 4096;
  localparam int BLUR_TAPS     = 9;
  localparam int IDLE_PCT      = 14;
  localparam int RANDOM_BEATS  = 260;
  localparam int EDGE_BEATS    = 40;
  localparam int SETTLE_CYCLES = 10;
  localparam int END_CYCLES    = 20;
  localparam int QUIET_LIMIT   = 2000;

  typedef struct packed {
    logic [bb3_pkg::DATA_W-1:0] word;
    logic                       last;
  } blur_px_t;

  typedef enum logic [1:0] {ROW_BEAT, ROW_SET_W, ROW_SET_H} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic                       act;
    logic [bb3_pkg::DATA_W-1:0] data;
    bit                         typed;
    blur_px_t                   fixed;
  } dir_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_action;
  logic [bb3_pkg::DATA_W-1:0] in_source_pixel;
  logic                       out_valid;
  logic                       out_ready;
  logic [bb3_pkg::DATA_W-1:0] out_blurred_pixel;
  logic                       out_last_of_frame;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [bb3_pkg::ADDR_W-1:0] cfg_paddr;
  logic [bb3_pkg::DATA_W-1:0] cfg_pwdata;
  logic [bb3_pkg::DATA_W-1:0] cfg_prdata;
  logic                       cfg_pready;

  // Behavioral blur state
  logic [bb3_pkg::FW_W-1:0]       width_reg;
  logic [bb3_pkg::FH_W-1:0]       height_reg;
  bb3_pkg::rgb_t                  older_row [0:MAX_LINE-1];
  bb3_pkg::rgb_t                  newer_row [0:MAX_LINE-1];
  logic [5:0][bb3_pkg::RGB_W-1:0] win_cols;
  int unsigned                    in_col, in_row, out_col, out_row;

  blur_px_t    pending_blur [$];
  dir_row_t    dir_rows [$];
  bit          no_idle;
  int          mismatches;
  int unsigned beats_in, live_beats, pixels_out, geometries, quiet_cycles;

  box_blur_3x3_rgb u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_source_pixel  (in_source_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_blurred_pixel(out_blurred_pixel),
    .out_last_of_frame(out_last_of_frame),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_LINE) return MAX_LINE;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_ROWS) return MAX_ROWS;
    return 32'(height_reg);
  endfunction

  function automatic void restart_frame();
    win_cols = '0;
    in_col   = 0;
    in_row   = 0;
    out_col  = 0;
    out_row  = 0;
  endfunction

  // Advance the blur by one beat; return 1 when the beat completes a window
  function automatic bit blur_step(input logic act, input logic [bb3_pkg::DATA_W-1:0] data,
                                   output blur_px_t res);
    int unsigned w, h, r, c, n, rs, gs, bs;
    logic [2:0][bb3_pkg::RGB_W-1:0] cur;
    logic [8:0][bb3_pkg::RGB_W-1:0] taps;
    logic [bb3_pkg::BYTE_W-1:0]     ra, ga, ba;
    w   = eff_width();
    h   = eff_height();
    r   = in_row;
    c   = in_col % MAX_LINE;
    res = '0;
    // a pad inside the frame leaves everything untouched
    if (act == bb3_pkg::ACT_PAD && r < h) return 1'b0;
    live_beats++;
    // past the last row every beat counts as a black pad
    cur[2] = (r < h) ? data[bb3_pkg::DATA_W-1 -: bb3_pkg::RGB_W] : '0;
    cur[0] = (r >= 2) ? older_row[c] : '0;
    cur[1] = (r >= 1 && r <= h) ? newer_row[c] : '0;
    older_row[c] = newer_row[c];
    newer_row[c] = cur[2];
    taps = {cur, win_cols};
    n = 0;
    // column zero closes the right edge of the row above
    if (c == 0) begin
      if (r >= 2) n = 6;
      win_cols = {cur, {(3 * bb3_pkg::RGB_W){1'b0}}};
    end else begin
      if (r >= 1) n = BLUR_TAPS;
      win_cols = {cur, win_cols[5:3]};
    end
    rs = 0;
    gs = 0;
    bs = 0;
    for (int i = 0; i < n; i++) begin
      rs += 32'(taps[i][23:16]);
      gs += 32'(taps[i][15:8]);
      bs += 32'(taps[i][7:0]);
    end
    ra = bb3_pkg::BYTE_W'(rs / BLUR_TAPS);
    ga = bb3_pkg::BYTE_W'(gs / BLUR_TAPS);
    ba = bb3_pkg::BYTE_W'(bs / BLUR_TAPS);
    res.word = {ra, ga, ba, bb3_pkg::ALPHA_OPAQUE};
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    in_col = c;
    in_row = r & 32'h1FFF;
    if (n == 0) return 1'b0;
    res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
    if (res.last) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row = (out_row + 1) & 32'hFFF;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [bb3_pkg::DATA_W-1:0] rand_pixel();
    logic [bb3_pkg::DATA_W-1:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0: v = '0;
      1: v = '1;
      // every byte saturated one way or the other
      2: for (int b = 0; b < 4; b++) v[8*b +: 8] = {8{v[8*b]}};
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_row(input row_kind_t kind, input logic act,
                         input logic [bb3_pkg::DATA_W-1:0] data, input bit typed,
                         input logic [bb3_pkg::DATA_W-1:0] word, input logic last);
    dir_row_t row;
    row.kind  = kind;
    row.act   = act;
    row.data  = data;
    row.typed = typed;
    row.fixed = {word, last};
    dir_rows.push_back(row);
  endtask

  // Offer one input beat, hold it until taken, then record what it should produce
  task automatic send_beat(input logic act, input logic [bb3_pkg::DATA_W-1:0] data,
                           input bit typed, input blur_px_t fixed);
    blur_px_t res;
    bit       emit;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_source_pixel <= data;
    do @(posedge clk); while (!in_ready);
    beats_in++;
    emit = blur_step(act, data, res);
    if (typed) pending_blur.push_back(fixed);
    else if (emit) pending_blur.push_back(res);
  endtask

  // Drop valid, wait for every blurred pixel, then let the pipeline empty
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_blur.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic idx,
                            input logic [bb3_pkg::DATA_W-1:0] wdata,
                            output logic [bb3_pkg::DATA_W-1:0] rdata);
    logic [bb3_pkg::ADDR_W-1:0] addr;
    addr = '0;
    addr[bb3_pkg::REG_SEL_BIT] = idx;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic idx, input logic [bb3_pkg::DATA_W-1:0] want);
    logic [bb3_pkg::DATA_W-1:0] got;
    apb_access(1'b0, idx, '0, got);
    if (got !== want) begin
      mismatches++;
      $display("%0t register %0d readback: expected %h, got %h", $time, idx, want, got);
    end
  endtask

  task automatic set_reg(input logic idx, input logic [bb3_pkg::DATA_W-1:0] val);
    logic [bb3_pkg::DATA_W-1:0] unused;
    apb_access(1'b1, idx, val, unused);
    if (idx == bb3_pkg::REG_FRAME_WIDTH) width_reg = val[bb3_pkg::FW_W-1:0];
    else height_reg = val[bb3_pkg::FH_W-1:0];
    restart_frame();
    check_reg(idx, (idx == bb3_pkg::REG_FRAME_WIDTH) ? bb3_pkg::DATA_W'(width_reg)
                                                     : bb3_pkg::DATA_W'(height_reg));
  endtask

  task automatic set_geometry(input logic [bb3_pkg::DATA_W-1:0] w_val,
                              input logic [bb3_pkg::DATA_W-1:0] h_val);
    drain_block();
    set_reg(bb3_pkg::REG_FRAME_WIDTH, w_val);
    set_reg(bb3_pkg::REG_FRAME_HEIGHT, h_val);
    geometries++;
  endtask

  // Stream one frame of random pixels plus its flush; stop early at beat stop_at if nonzero
  task automatic stream_frame(input int unsigned stop_at);
    int unsigned w, h;
    w = eff_width();
    h = eff_height();
    for (int k = 0; k < w * h; k++) begin
      if (stop_at != 0 && k == stop_at) return;
      if ($urandom_range(99) < 4) send_beat(bb3_pkg::ACT_PAD, $urandom, 1'b0, '0);
      send_beat(bb3_pkg::ACT_PIXEL, rand_pixel(), 1'b0, '0);
    end
    // flush: pads, with some stray pixels that count as pads
    for (int k = 0; k <= w; k++)
      send_beat(($urandom_range(4) == 0) ? bb3_pkg::ACT_PIXEL : bb3_pkg::ACT_PAD, $urandom,
                1'b0, '0);
  endtask

  // Result side: random back-pressure, compare every beat with the oldest prediction
  initial begin
    blur_px_t want;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        pixels_out++;
        if (pending_blur.size() == 0) begin
          mismatches++;
          $display("%0t unexpected beat: expected none, got %h last %b", $time,
                   out_blurred_pixel, out_last_of_frame);
        end else begin
          want = pending_blur.pop_front();
          if (out_blurred_pixel !== want.word) begin
            mismatches++;
            $display("%0t blurred_pixel: expected %h, got %h", $time, want.word,
                     out_blurred_pixel);
          end
          if (out_last_of_frame !== want.last) begin
            mismatches++;
            $display("%0t last_of_frame: expected %b, got %b", $time, want.last,
                     out_last_of_frame);
          end
        end
      end
      out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t watchdog: no beat taken for %0d cycles", $time, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dir_row_t                   row;
    int unsigned                w_raw, h_raw, area, base;
    int                         nframes;
    logic [bb3_pkg::DATA_W-1:0] w_val, h_val;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_action       <= bb3_pkg::ACT_PIXEL;
    in_source_pixel <= '0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    no_idle      = 1'b0;
    mismatches   = 0;
    beats_in     = 0;
    live_beats   = 0;
    pixels_out   = 0;
    geometries   = 0;
    quiet_cycles = 0;
    width_reg    = 11'd640;
    height_reg   = 13'd480;
    restart_frame();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values of the geometry registers
    check_reg(bb3_pkg::REG_FRAME_WIDTH, 32'd640);
    check_reg(bb3_pkg::REG_FRAME_HEIGHT, 32'd480);

    // 1x1 frames: single pixel, pad inside the frame, stray pixel after the last row
    add_row(ROW_SET_W, bb3_pkg::ACT_PIXEL, 32'd1, 1'b0, '0, 1'b0);
    add_row(ROW_SET_H, bb3_pkg::ACT_PIXEL, 32'd1, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PAD,   32'h0000_0000, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PIXEL, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PAD,   32'h0000_0000, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PAD,   32'hFFFF_FFFF, 1'b1, 32'h1C1C_1CFF, 1'b1);
    add_row(ROW_BEAT, bb3_pkg::ACT_PIXEL, 32'h0000_0055, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PAD,   32'h0000_0000, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PAD,   32'h0000_0000, 1'b1, 32'h0000_00FF, 1'b1);
    add_row(ROW_BEAT, bb3_pkg::ACT_PIXEL, 32'h1234_5678, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PIXEL, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PAD,   32'h0000_0000, 1'b1, 32'h0205_09FF, 1'b1);
    // zero width and height behave as one
    add_row(ROW_SET_W, bb3_pkg::ACT_PIXEL, 32'd0, 1'b0, '0, 1'b0);
    add_row(ROW_SET_H, bb3_pkg::ACT_PIXEL, 32'd0, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PIXEL, 32'h9090_9000, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PAD,   32'h0000_0000, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PIXEL, 32'h5A5A_5A5A, 1'b1, 32'h1010_10FF, 1'b1);
    // 3x2 frame with saturated channels, checked against the model
    add_row(ROW_SET_W, bb3_pkg::ACT_PIXEL, 32'd3, 1'b0, '0, 1'b0);
    add_row(ROW_SET_H, bb3_pkg::ACT_PIXEL, 32'd2, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PIXEL, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PIXEL, 32'h0000_0000, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PIXEL, 32'hFF00_FF00, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PAD,   32'hA5A5_A5A5, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PIXEL, 32'h00FF_00FF, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PIXEL, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    add_row(ROW_BEAT, bb3_pkg::ACT_PIXEL, 32'h8080_8080, 1'b0, '0, 1'b0);
    for (int i = 0; i < 4; i++)
      add_row(ROW_BEAT, bb3_pkg::ACT_PAD, 32'h0000_0000, 1'b0, '0, 1'b0);

    // Walk the directed script
    for (int i = 0; i < dir_rows.size(); i++) begin
      row = dir_rows[i];
      case (row.kind)
        ROW_SET_W: begin
          drain_block();
          set_reg(bb3_pkg::REG_FRAME_WIDTH, row.data);
        end
        ROW_SET_H: begin
          drain_block();
          set_reg(bb3_pkg::REG_FRAME_HEIGHT, row.data);
        end
        default: send_beat(row.act, row.data, row.typed, row.fixed);
      endcase
    end

    // Random small frames, some aborted by a geometry rewrite, one stretch without idling
    base = live_beats;
    while (live_beats - base < RANDOM_BEATS) begin
      no_idle = (live_beats - base >= 100) && (live_beats - base < 200);
      w_raw = ($urandom_range(7) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 5);
      h_raw = ($urandom_range(7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
      w_val = w_raw;
      h_val = h_raw;
      if ($urandom_range(3) == 0)
        w_val[bb3_pkg::DATA_W-1:bb3_pkg::FW_W] = (bb3_pkg::DATA_W - bb3_pkg::FW_W)'($urandom);
      if ($urandom_range(3) == 0)
        h_val[bb3_pkg::DATA_W-1:bb3_pkg::FH_W] = (bb3_pkg::DATA_W - bb3_pkg::FH_W)'($urandom);
      set_geometry(w_val, h_val);
      area = eff_width() * eff_height();
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
        if (area > 1 && $urandom_range(9) == 0) begin
          stream_frame($urandom_range(1, area - 1));
          break;
        end
        stream_frame(0);
      end
    end

    // Extreme geometries, streamed as the opening stretch of a frame
    no_idle = 1'b1;
    set_geometry(32'd1024, 32'd2);
    stream_frame(EDGE_BEATS);
    no_idle = 1'b0;
    set_geometry(32'h0000_07FF, 32'd1);
    stream_frame(EDGE_BEATS);
    set_geometry(32'd1, 32'd4096);
    stream_frame(EDGE_BEATS);
    set_geometry(32'd0, 32'h0000_1FFF);
    stream_frame(EDGE_BEATS);

    drain_block();
    repeat (END_CYCLES) @(posedge clk);

    $display("Run covered %0d input beats (%0d ignored pads) and %0d blurred pixels,",
             beats_in, beats_in - live_beats, pixels_out);
    $display("over %0d geometries, the widest and tallest as partial frames.", geometries);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
